// ----- hdl/rvalu_pkg.sv -----
// rvalu_pkg: shared types and constants for the rv32im alu
// no dependencies
package rvalu_pkg;
    localparam int XLEN = 32;
    localparam int CELLS = XLEN + 1;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_AND  = 4'd2,
        OP_OR   = 4'd3,
        OP_XOR  = 4'd4,
        OP_SLL  = 4'd5,
        OP_SRL  = 4'd6,
        OP_SLT  = 4'd7,
        OP_SLTU = 4'd8,
        OP_MUL  = 4'd9,
        OP_DIV  = 4'd10,
        OP_REM  = 4'd11,
        OP_NONE = 4'd12
    } op_t;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_MEXT = 7'd1;
    localparam logic [6:0] F7_SUB  = 7'd32;
    localparam logic [2:0] CLS_ADD = 3'd0;
    localparam logic [2:0] CLS_SUB = 3'd1;

    // payload carried from cell to cell
    typedef struct packed {
        logic             valid;
        op_t              op;
        logic [XLEN-1:0]  res;     // finished result for non-divide ops
        logic [XLEN-1:0]  rem;     // partial remainder
        logic [XLEN-1:0]  quo;     // dividend bits shifting out, quotient in
        logic [XLEN-1:0]  dvs;     // divisor magnitude
        logic             neg_q;
        logic             neg_r;
        logic             dz;
        logic [XLEN-1:0]  a;
    } cell_t;
endpackage

// ----- hdl/rvalu_front.sv -----
// rvalu_front: decode and combinational non-divide ops, feeds the divider cell row
// depends on rvalu_pkg
module rvalu_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [2:0]               op_class,
    input  logic [2:0]               funct3,
    input  logic [6:0]               funct7,
    input  logic [rvalu_pkg::XLEN-1:0] operand_a,
    input  logic [rvalu_pkg::XLEN-1:0] operand_b,
    output rvalu_pkg::cell_t         cell_out
);
    import rvalu_pkg::*;

    op_t             op;
    logic [XLEN-1:0] res;
    logic [XLEN-1:0] ua;
    logic [XLEN-1:0] ub;
    logic [2*XLEN-1:0] prod;
    cell_t           cell_reg;
    cell_t           cell_next;

    always_comb begin
        op = OP_NONE;
        if (op_class == CLS_ADD) begin
            op = OP_ADD;
        end else if (op_class == CLS_SUB) begin
            op = OP_SUB;
        end else if (funct7 == F7_MEXT && funct3 == F3_ADD) begin
            op = OP_MUL;
        end else if (funct7 == F7_MEXT && funct3 == F3_XOR) begin
            op = OP_DIV;
        end else if (funct7 == F7_MEXT && funct3 == F3_OR) begin
            op = OP_REM;
        end else begin
            unique case (funct3)
                F3_ADD: begin
                    if (funct7 == F7_BASE) op = OP_ADD;
                    else if (funct7 == F7_SUB) op = OP_SUB;
                    else op = OP_NONE;
                end
                F3_AND:  op = OP_AND;
                F3_OR:   op = OP_OR;
                F3_XOR:  op = OP_XOR;
                F3_SLL:  op = OP_SLL;
                F3_SRL:  op = OP_SRL;
                F3_SLT:  op = OP_SLT;
                F3_SLTU: op = OP_SLTU;
                default: op = OP_NONE;
            endcase
        end
    end

    assign prod = operand_a * operand_b;
    assign ua = operand_a[XLEN-1] ? (~operand_a + 1'b1) : operand_a;
    assign ub = operand_b[XLEN-1] ? (~operand_b + 1'b1) : operand_b;

    always_comb begin
        case (op)
            OP_ADD:  res = operand_a + operand_b;
            OP_SUB:  res = operand_a - operand_b;
            OP_AND:  res = operand_a & operand_b;
            OP_OR:   res = operand_a | operand_b;
            OP_XOR:  res = operand_a ^ operand_b;
            OP_SLL:  res = operand_a << operand_b[4:0];
            OP_SRL:  res = operand_a >> operand_b[4:0];
            OP_SLT:  res = {{(XLEN-1){1'b0}}, ($signed(operand_a) < $signed(operand_b))};
            OP_SLTU: res = {{(XLEN-1){1'b0}}, (operand_a < operand_b)};
            OP_MUL:  res = prod[XLEN-1:0];
            default: res = '0;
        endcase
    end

    always_comb begin
        cell_next.valid = in_valid;
        cell_next.op    = op;
        cell_next.res   = res;
        cell_next.rem   = '0;
        cell_next.quo   = ua;
        cell_next.dvs   = ub;
        cell_next.neg_q = operand_a[XLEN-1] ^ operand_b[XLEN-1];
        cell_next.neg_r = operand_a[XLEN-1];
        cell_next.dz    = (operand_b == '0);
        cell_next.a     = operand_a;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;
endmodule

// ----- hdl/rvalu_cell.sv -----
// rvalu_cell: one restoring-division step, passes the item to the next cell
// depends on rvalu_pkg
module rvalu_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  rvalu_pkg::cell_t cell_in,
    output rvalu_pkg::cell_t cell_out
);
    import rvalu_pkg::*;

    cell_t           cell_reg;
    cell_t           cell_next;
    logic [XLEN:0]   trial;
    logic [XLEN:0]   diff;

    assign trial = {cell_in.rem, cell_in.quo[XLEN-1]};
    assign diff  = trial - {1'b0, cell_in.dvs};

    always_comb begin
        cell_next = cell_in;
        if (!diff[XLEN]) begin
            cell_next.rem = diff[XLEN-1:0];
            cell_next.quo = {cell_in.quo[XLEN-2:0], 1'b1};
        end else begin
            cell_next.rem = trial[XLEN-1:0];
            cell_next.quo = {cell_in.quo[XLEN-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;
endmodule

// ----- hdl/rvalu_back.sv -----
// rvalu_back: sign fix, special cases and zero flag at the end of the row
// depends on rvalu_pkg
module rvalu_back (
    input  rvalu_pkg::cell_t          cell_in,
    output logic [rvalu_pkg::XLEN-1:0] result,
    output logic                      zero
);
    import rvalu_pkg::*;

    always_comb begin
        case (cell_in.op)
            OP_DIV: begin
                if (cell_in.dz) result = '1;
                else result = cell_in.neg_q ? (~cell_in.quo + 1'b1) : cell_in.quo;
            end
            OP_REM: begin
                if (cell_in.dz) result = cell_in.a;
                else result = cell_in.neg_r ? (~cell_in.rem + 1'b1) : cell_in.rem;
            end
            default: result = cell_in.res;
        endcase
    end

    assign zero = (result == '0);
endmodule

// ----- hdl/rv32im_alu_with_control.sv -----
// rv32im_alu_with_control: rv32im alu, decode plus a row of division cells
// path: decode register, then 32 division cells, then the output register
// every operation takes the same path
// throughput: one request per cycle while the row is not stalled; all operations flow through the same row
// stalls: the whole row holds while the output has a result and m_tready is low
// reset: aresetn synchronous active low clears every valid bit in the row
// depends on rvalu_pkg, rvalu_front, rvalu_cell, rvalu_back
module rv32im_alu_with_control (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op_class[2:0], funct3[5:3], funct7[12:6], operand_a[44:13], operand_b[76:45], zero fill
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // alu_result[31:0], is_zero[32], zero fill
    output logic [39:0] m_tdata
);
    import rvalu_pkg::*;

    // whole row advances together; stalls only when the output holds a result and m_tready is low
    cell_t chain [CELLS];
    logic  en;
    logic  out_valid_reg;
    logic [XLEN-1:0] out_res_reg;
    logic  out_zero_reg;
    logic [XLEN-1:0] back_res;
    logic  back_zero;

    // output register empties or is being taken
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    rvalu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .op_class  (s_tdata[2:0]),
        .funct3    (s_tdata[5:3]),
        .funct7    (s_tdata[12:6]),
        .operand_a (s_tdata[44:13]),
        .operand_b (s_tdata[76:45]),
        .cell_out  (chain[0])
    );

    // one quotient bit per cell, msb first
    for (genvar i = 0; i < XLEN; i++) begin : g_row
        rvalu_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    rvalu_back u_back (
        .cell_in (chain[CELLS-1]),
        .result  (back_res),
        .zero    (back_zero)
    );

    // output register: holds the request result until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= chain[CELLS-1].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_res_reg  <= back_res;
            out_zero_reg <= back_zero;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_zero_reg, out_res_reg};
endmodule

// ----- tb/sv/testbench.sv -----
// testbench for rv32im_alu_with_control: directed and random alu requests checked
// against an in-bench predictor; depends on rvalu_pkg and the alu top level
`timescale 1ns / 100ps

module testbench;
    import rvalu_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    // expected alu_result and is_zero, oldest first
    logic [32:0] alu_expect_q[$];
    int          error_count;
    int          sent_count;
    int          checked_count;
    int          idle_cycles;
    bit          rx_stall_on;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    rv32im_alu_with_control DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // signed divide and remainder with the risc-v rules for zero and overflow
    function automatic logic [31:0] div_rem_calc(logic [31:0] a, logic [31:0] b, bit want_rem);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        logic [31:0] r;
        ua = a[31] ? (32'd0 - a) : a;
        ub = b[31] ? (32'd0 - b) : b;
        if (b == 32'd0) begin
            return want_rem ? a : 32'hFFFF_FFFF;
        end
        q = ua / ub;
        r = ua % ub;
        if (want_rem) begin
            return a[31] ? (32'd0 - r) : r;
        end
        return (a[31] ^ b[31]) ? (32'd0 - q) : q;
    endfunction

    function automatic logic [31:0] alu_calc(logic [2:0] cls, logic [2:0] f3, logic [6:0] f7,
                                             logic [31:0] a, logic [31:0] b);
        logic [63:0] prod;
        if (cls == CLS_ADD) return a + b;
        if (cls == CLS_SUB) return a - b;
        if (f7 == F7_MEXT) begin
            if (f3 == F3_ADD) begin
                prod = {32'd0, a} * {32'd0, b};
                return prod[31:0];
            end
            if (f3 == F3_XOR) return div_rem_calc(a, b, 1'b0);
            if (f3 == F3_OR) return div_rem_calc(a, b, 1'b1);
        end
        case (f3)
            F3_ADD: begin
                if (f7 == F7_BASE) return a + b;
                if (f7 == F7_SUB) return a - b;
                return 32'd0;
            end
            F3_AND:  return a & b;
            F3_OR:   return a | b;
            F3_XOR:  return a ^ b;
            F3_SLL:  return a << b[4:0];
            F3_SRL:  return a >> b[4:0];
            F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
            default: return 32'd0;
        endcase
    endfunction

    // gap length: mostly zero or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one request: predict, then hold valid until accepted
    task automatic send_request(logic [2:0] cls, logic [2:0] f3, logic [6:0] f7,
                                logic [31:0] a, logic [31:0] b, bit allow_gap);
        logic [31:0] r;
        int gap;
        gap = allow_gap ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        r = alu_calc(cls, f3, f7, a, b);
        alu_expect_q.insert(alu_expect_q.size(), {(r == 32'd0), r});
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, b, a, f7, f3, cls};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic wait_empty();
        s_tvalid <= 1'b0;
        while (alu_expect_q.size() != 0) @(posedge aclk);
    endtask

    // result sink: random backpressure with unstalled stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) rx_stall_on = !rx_stall_on;
            if (!rx_stall_on) begin
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < 4) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(8, 25)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) < 65);
            end
        end
    end

    // result checker against the oldest expectation
    always @(posedge aclk) begin
        logic [32:0] exp_item;
        if (aresetn && m_tvalid && m_tready) begin
            if (alu_expect_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                error_count++;
            end else begin
                exp_item = alu_expect_q.pop_front();
                if (m_tdata[31:0] !== exp_item[31:0]) begin
                    $display("%0t: alu_result mismatch, expected %h, actual %h",
                             $time, exp_item[31:0], m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[32] !== exp_item[32]) begin
                    $display("%0t: is_zero mismatch, expected %b, actual %b",
                             $time, exp_item[32], m_tdata[32]);
                    error_count++;
                end
                checked_count++;
            end
        end
    end

    // watchdog on cycles with no request or result accepted
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d results pending",
                         $time, alu_expect_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // edge operands and every operation class
    task automatic test_directed();
        send_request(CLS_ADD, 3'd0, 7'd0, 32'hFFFF_FFFF, 32'd1, 0);
        send_request(CLS_SUB, 3'd7, 7'd127, 32'd0, 32'd1, 0);
        send_request(3'd2, F3_ADD, F7_BASE, 32'h7FFF_FFFF, 32'd1, 0);
        send_request(3'd3, F3_ADD, F7_SUB, 32'd5, 32'd5, 0);
        // unmatched funct7 with funct3 zero
        send_request(3'd4, F3_ADD, 7'd127, 32'd3, 32'd4, 0);
        send_request(3'd7, F3_AND, 7'd127, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 0);
        send_request(3'd2, F3_OR, F7_BASE, 32'h0F0F_0000, 32'h0000_F0F0, 0);
        send_request(3'd2, F3_XOR, F7_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(3'd2, F3_SLL, F7_BASE, 32'h8000_0001, 32'hFFFF_FFFF, 0);
        // right shift stays logical even with funct7 of 32
        send_request(3'd2, F3_SRL, F7_SUB, 32'h8000_0000, 32'd31, 0);
        send_request(3'd2, F3_SLT, F7_BASE, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_request(3'd2, F3_SLTU, F7_BASE, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_request(3'd2, F3_ADD, F7_MEXT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(3'd2, F3_XOR, F7_MEXT, 32'hFFFF_FFF9, 32'd2, 0);
        send_request(3'd2, F3_OR, F7_MEXT, 32'hFFFF_FFF9, 32'd2, 0);
        // divide and remainder by zero
        send_request(3'd2, F3_XOR, F7_MEXT, 32'h1234_5678, 32'd0, 0);
        send_request(3'd2, F3_OR, F7_MEXT, 32'h1234_5678, 32'd0, 0);
        // signed overflow
        send_request(3'd2, F3_XOR, F7_MEXT, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_request(3'd2, F3_OR, F7_MEXT, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        // m-extension funct7 on a base-only funct3
        send_request(3'd2, F3_SLL, F7_MEXT, 32'd1, 32'd4, 0);
        send_request(3'd2, F3_AND, F7_MEXT, 32'hF0F0_F0F0, 32'hFFFF_0000, 0);
        wait_empty();
    endtask

    // random requests weighted toward the decoded classes and edge operands
    task automatic test_random(int count);
        logic [2:0]  cls;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a;
        logic [31:0] b;
        int roll;
        for (int i = 0; i < count; i++) begin
            cls = ($urandom_range(0, 9) < 2) ? 3'($urandom_range(0, 1)) : 3'($urandom);
            f3 = 3'($urandom);
            roll = $urandom_range(0, 9);
            if (roll < 3) f7 = F7_MEXT;
            else if (roll < 5) f7 = F7_BASE;
            else if (roll < 7) f7 = F7_SUB;
            else f7 = 7'($urandom);
            a = $urandom;
            b = $urandom;
            roll = $urandom_range(0, 19);
            if (roll == 0) b = 32'd0;
            else if (roll == 1) begin
                a = 32'h8000_0000;
                b = 32'hFFFF_FFFF;
            end else if (roll < 5) b = 32'($urandom_range(0, 40)) - 32'd20;
            else if (roll == 5) a = b;
            send_request(cls, f3, f7, a, b, 1);
            if (i == count / 2) wait_empty();
        end
        wait_empty();
    endtask

    initial begin
        sent_count = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(1530);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("sent %0d alu requests over all classes and funct codes, %0d results checked",
                 sent_count, checked_count);
        if (error_count == 0 && alu_expect_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d errors, %0d results missing", error_count, alu_expect_q.size());
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
